@@ rtl/core/sfrm_pkg.sv @@
// ----------------------------------------------------------------------------
// sfrm_pkg
// Shared types, sizes and default factor table of the station factor
// running-mean table.
// ----------------------------------------------------------------------------
package sfrm_pkg;

   // table geometry
   localparam int MAX_STATIONS  = 16;
   localparam int DEFAULT_COUNT = 7;
   localparam int TABLE_LEN     = 7;
   localparam int ADDR_W        = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
   localparam int COUNT_W       = $clog2(MAX_STATIONS + 1);
   localparam int USED          = (DEFAULT_COUNT < TABLE_LEN) ? DEFAULT_COUNT : TABLE_LEN;
   localparam int TAB_W         = (TABLE_LEN > 1) ? $clog2(TABLE_LEN) : 1;

   // field widths
   localparam int VALUE_W   = 32;
   localparam int WEIGHT_W  = 16;
   localparam int INDEX_W   = 16;
   localparam int ENTRY_W   = VALUE_W + WEIGHT_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CFG_W      = 5;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1);
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};

   // register indexes
   localparam logic REG_STATION_COUNT = 1'b0;

   // default factors, Q16.16
   localparam logic signed [VALUE_W-1:0] DEFAULT_Q16 [TABLE_LEN] = '{
      32'sd430855, 32'sd457267, 32'sd475388, 32'sd492959,
      32'sd523047, 32'sd529273, 32'sd530842
   };

   typedef enum logic [1:0] {
      OP_GET    = 2'd0,
      OP_EVAL   = 2'd1,
      OP_SET    = 2'd2,
      OP_UPDATE = 2'd3
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic [INDEX_W-1:0]         station_index;
      logic signed [VALUE_W-1:0]  value_in;
   } req_word_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  value_out;
      logic [WEIGHT_W-1:0]        weight_out;
      logic                       index_error;
   } rsp_word_type;

   // default factor of a station; stations past the list repeat the last one
   function automatic logic signed [VALUE_W-1:0] default_factor(
      input logic [ADDR_W-1:0] addr
   );
      logic [TAB_W-1:0] k;
      if (int'(addr) < USED) begin
         k = TAB_W'(addr);
      end else begin
         k = TAB_W'(USED - 1);
      end
      return DEFAULT_Q16[k];
   endfunction

endpackage

@@ rtl/core/sfrm_ram.sv @@
// ----------------------------------------------------------------------------
// sfrm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
   input  logic [WIDTH-1:0]                              wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
   output logic [WIDTH-1:0]                              rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata <= mem_ff[raddr];
   end

endmodule

@@ rtl/core/station_factor_running_mean_table_unit.sv @@
// ----------------------------------------------------------------------------
// station_factor_running_mean_table_unit
// Per-station Q16.16 factor table with get, evaluate, set and running-mean
// update, sequenced around one shift-subtract divider.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one word carries op, station_index and value_in. req_stall
//   is high while a word is being worked on; one word is taken at a time.
//   rsp channel: one result word per request (value_out, weight_out,
//   index_error), held in an output register until rsp_stall drops. The
//   next request is taken while a result still waits there.
//   csr port: register 0 is station_count (reads back the saturated count).
//   Writing it reloads every entry with its default factor and weight 1.
// Steps, from request accept to rsp_valid:
//   get, evaluate, set and any out-of-range index: lookup and result stages.
//   update: table read, difference and magnitude stages, then the radix-2
//   restoring divider, which retires one quotient bit per cycle, then sign
//   fix, sum and result stages.
// Reset: station_count is 0 and all entries read as their defaults; per-entry
//   valid bits make the reload immediate, with no clearing pass.
// A stalled result holds the last stage; the block then takes one more
//   request and waits with it finished until the output register frees.
// ----------------------------------------------------------------------------
module station_factor_running_mean_table_unit
   import sfrm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_word,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_word,
   // configuration port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int DIV_W   = VALUE_W;
   localparam int DCNT_W  = $clog2(DIV_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_PREP,
      ST_ABS,
      ST_DIV,
      ST_FIX,
      ST_SUM,
      ST_DONE
   } state_type;

   // registers
   state_type                 state_ff, state_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [MAX_STATIONS-1:0]   valid_ff, valid_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_word_type              rsp_word_ff, rsp_word_in;
   op_type                    op_ff, op_in;
   logic                      err_ff, err_in;
   logic signed [VALUE_W-1:0] sample_ff, sample_in;
   logic [ADDR_W-1:0]         addr_ff, addr_in;
   logic                      rd_valid_ff, rd_valid_in;
   logic signed [VALUE_W-1:0] old_ff, old_in;
   logic [WEIGHT_W-1:0]       wgt_ff, wgt_in;
   logic signed [VALUE_W:0]   diff_ff, diff_in;
   logic                      neg_ff, neg_in;
   logic [DIV_W-1:0]          quot_ff, quot_in;
   logic [WEIGHT_W-1:0]       rem_ff, rem_in;
   logic [DCNT_W-1:0]         dcnt_ff, dcnt_in;
   logic signed [VALUE_W-1:0] res_val_ff, res_val_in;
   logic [WEIGHT_W-1:0]       res_wgt_ff, res_wgt_in;

   // combinational helpers
   logic                      req_take;
   logic                      csr_write;
   logic                      out_free;
   logic                      idx_err;
   logic [COUNT_W-1:0]        last_cnt;
   logic [ADDR_W-1:0]         rd_addr;
   logic [CFG_W-1:0]          cfg_val;
   logic signed [VALUE_W-1:0] entry_val;
   logic [WEIGHT_W-1:0]       entry_wgt;
   logic [WEIGHT_W:0]         trial;
   logic [WEIGHT_W:0]         shifted;
   logic signed [VALUE_W-1:0] sum_val;
   logic                      ram_we;
   logic [ENTRY_W-1:0]        ram_wdata;
   logic [ENTRY_W-1:0]        ram_rdata;

   assign req_take   = req_valid && !req_stall;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign cfg_val    = csr_pwdata[CFG_W-1:0];

   // range check and read address for the incoming word
   assign idx_err  = req_word.station_index >= INDEX_W'(count_ff);
   assign last_cnt = count_ff - COUNT_W'(1);
   assign rd_addr  = idx_err ? last_cnt[ADDR_W-1:0]
                             : req_word.station_index[ADDR_W-1:0];

   // entry as read: a never-written entry shows its default
   assign entry_val = rd_valid_ff ? ram_rdata[VALUE_W-1:0] : default_factor(addr_ff);
   assign entry_wgt = rd_valid_ff ? ram_rdata[ENTRY_W-1:VALUE_W] : WEIGHT_ONE;

   // divider step for update: shift in next dividend bit, trial subtract
   assign shifted = {rem_ff, quot_ff[DIV_W-1]};
   assign trial   = shifted - {1'b0, wgt_ff};

   assign sum_val = old_ff + quot_ff;

   // table writes: set in the lookup stage, update in the sum stage
   assign ram_we    = (state_ff == ST_LOOK && !err_ff && op_ff == OP_SET) ||
                      (state_ff == ST_SUM);
   assign ram_wdata = (state_ff == ST_SUM) ? {wgt_ff, sum_val} : {WEIGHT_ONE, sample_ff};

   sfrm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_STATIONS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (addr_ff),
      .wdata (ram_wdata),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   // next-state and datapath
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      op_in        = op_ff;
      err_in       = err_ff;
      sample_in    = sample_ff;
      addr_in      = addr_ff;
      rd_valid_in  = rd_valid_ff;
      old_in       = old_ff;
      wgt_in       = wgt_ff;
      diff_in      = diff_ff;
      neg_in       = neg_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      res_val_in   = res_val_ff;
      res_wgt_in   = res_wgt_ff;

      // output register drains
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (ram_we) begin
         valid_in[addr_ff] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               op_in       = req_word.op;
               err_in      = idx_err;
               sample_in   = req_word.value_in;
               addr_in     = rd_addr;
               rd_valid_in = valid_ff[rd_addr];
               state_in    = ST_LOOK;
            end
         end
         ST_LOOK: begin
            old_in = entry_val;
            if (err_ff) begin
               res_val_in = (op_ff == OP_EVAL && count_ff != '0) ? entry_val : '0;
               res_wgt_in = '0;
               state_in   = ST_DONE;
            end else if (op_ff == OP_SET) begin
               res_val_in = sample_ff;
               res_wgt_in = WEIGHT_ONE;
               state_in   = ST_DONE;
            end else if (op_ff == OP_UPDATE) begin
               wgt_in   = (entry_wgt != WEIGHT_MAX) ? entry_wgt + WEIGHT_ONE : entry_wgt;
               state_in = ST_PREP;
            end else begin
               res_val_in = entry_val;
               res_wgt_in = entry_wgt;
               state_in   = ST_DONE;
            end
         end
         ST_PREP: begin
            diff_in  = {sample_ff[VALUE_W-1], sample_ff} - {old_ff[VALUE_W-1], old_ff};
            state_in = ST_ABS;
         end
         ST_ABS: begin
            // magnitude fits 32 bits: both operands are 32-bit signed
            neg_in   = diff_ff[VALUE_W];
            quot_in  = diff_ff[VALUE_W] ? DIV_W'(-diff_ff) : DIV_W'(diff_ff);
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!trial[WEIGHT_W]) begin
               rem_in = trial[WEIGHT_W-1:0];
            end else begin
               rem_in = shifted[WEIGHT_W-1:0];
            end
            quot_in = {quot_ff[DIV_W-2:0], !trial[WEIGHT_W]};
            dcnt_in = dcnt_ff + DCNT_W'(1);
            if (dcnt_ff == DCNT_W'(DIV_W - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            // truncation toward zero: apply sign to magnitude quotient
            quot_in  = neg_ff ? -quot_ff : quot_ff;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            res_val_in = sum_val;
            res_wgt_in = wgt_ff;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_word_in.value_out   = res_val_ff;
               rsp_word_in.weight_out  = res_wgt_ff;
               rsp_word_in.index_error = err_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // count write reloads defaults by dropping every valid bit
      if (csr_write && csr_paddr[2] == REG_STATION_COUNT) begin
         count_in = (int'(cfg_val) > MAX_STATIONS) ? COUNT_W'(MAX_STATIONS)
                                                   : COUNT_W'(cfg_val);
         valid_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         dcnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         dcnt_ff      <= dcnt_in;
      end
      rsp_word_ff <= rsp_word_in;
      op_ff       <= op_in;
      err_ff      <= err_in;
      sample_ff   <= sample_in;
      addr_ff     <= addr_in;
      rd_valid_ff <= rd_valid_in;
      old_ff      <= old_in;
      wgt_ff      <= wgt_in;
      diff_ff     <= diff_in;
      neg_ff      <= neg_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      res_val_ff  <= res_val_in;
      res_wgt_ff  <= res_wgt_in;
   end

   // ports
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_STATION_COUNT) ? CSR_DATA_W'(count_ff) : '0;

`ifndef ASSERT_OFF
   // a taken word always keeps the block busy for the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("request taken but block not busy next cycle");

   // divider step counter only runs inside the divide state
   a_dcnt_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DIV) |-> (dcnt_ff == '0))
      else $error("divider counter active outside divide");

   // the table is never written while idle
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff != ST_IDLE))
      else $error("table write while idle");

   // an out-of-range result carries no weight
   a_err_weight: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.index_error) |-> (rsp_word.weight_out == '0))
      else $error("index error with nonzero weight");
`endif

endmodule

@@ dv/station_factor_running_mean_table_unit_tb.sv @@
// ----------------------------------------------------------------------------
// station_factor_running_mean_table_unit_tb
// Self-checking bench for the station factor table. A scoreboard predicts
// each result word from its own copy of the table and the station count and
// checks the rsp channel in order. A short directed run covers range edges,
// default reload and extreme samples. Random phases follow, under several
// station counts and sender/receiver idle patterns, with one long receiver
// hold-off and one full drain in the middle of a phase.
// ----------------------------------------------------------------------------
module station_factor_running_mean_table_unit_tb
   import sfrm_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_CYCLES = 60;
   localparam logic [CSR_ADDR_W-1:0] COUNT_ADDR = CSR_ADDR_W'(4 * REG_STATION_COUNT);
   localparam int unsigned PHASE_WORDS = 125;

   // -------------------------------------------------------------------------
   // scoreboard: table predictor plus queue of expected result words
   // -------------------------------------------------------------------------
   class factor_table_scoreboard;
      logic signed [VALUE_W-1:0] factor_q [MAX_STATIONS];
      logic [WEIGHT_W-1:0]       weight_q [MAX_STATIONS];
      int unsigned               stations_used;
      rsp_word_type              expected_words [$];
      int unsigned               mismatches;
      int unsigned               results_checked;
      int unsigned               range_errors;
      int unsigned               op_seen [4];
      int unsigned               count_writes;
      int unsigned               peak_weight;

      function new();
         mismatches = 0;
         results_checked = 0;
         range_errors = 0;
         count_writes = 0;
         peak_weight = 1;
         foreach (op_seen[i]) op_seen[i] = 0;
         stations_used = 0;
         reload_table();
      endfunction

      // reset factors of each station; past the list the last one repeats
      function void reload_table();
         for (int i = 0; i < MAX_STATIONS; i++) begin
            case (i)
               0: factor_q[i] = 32'sd430855;
               1: factor_q[i] = 32'sd457267;
               2: factor_q[i] = 32'sd475388;
               3: factor_q[i] = 32'sd492959;
               4: factor_q[i] = 32'sd523047;
               5: factor_q[i] = 32'sd529273;
               default: factor_q[i] = 32'sd530842;
            endcase
            weight_q[i] = 16'd1;
         end
      endfunction

      // count write saturates and reloads every entry
      function void load_count(logic [CFG_W-1:0] raw);
         stations_used = (raw > MAX_STATIONS) ? MAX_STATIONS : raw;
         count_writes++;
         reload_table();
      endfunction

      function int unsigned pending();
         return expected_words.size();
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got %0h, expected %0h", what, got, want);
         mismatches++;
      endtask

      // accepted request word: apply it to the table, queue the result
      function void note_request(req_word_type w);
         rsp_word_type          res;
         int unsigned           idx;
         logic [WEIGHT_W-1:0]   wgt;
         longint                diff;
         res = '0;
         idx = w.station_index;
         op_seen[w.op]++;
         if (idx >= stations_used) begin
            res.index_error = 1'b1;
            range_errors++;
            if (w.op == OP_EVAL && stations_used > 0) begin
               res.value_out = factor_q[stations_used-1];
            end
         end else begin
            case (w.op)
               OP_SET: begin
                  factor_q[idx] = w.value_in;
                  weight_q[idx] = 16'd1;
               end
               OP_UPDATE: begin
                  wgt = weight_q[idx];
                  if (wgt != WEIGHT_MAX) wgt = wgt + 16'd1;
                  weight_q[idx] = wgt;
                  diff = longint'(w.value_in) - longint'(factor_q[idx]);
                  factor_q[idx] = VALUE_W'(longint'(factor_q[idx]) + diff / longint'(wgt));
                  if (wgt > peak_weight) peak_weight = wgt;
               end
               default: ;
            endcase
            res.value_out = factor_q[idx];
            res.weight_out = weight_q[idx];
         end
         expected_words.push_back(res);
      endfunction

      // accepted result word against the oldest expectation
      task check_result(rsp_word_type got);
         rsp_word_type want;
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected result word", got.value_out, 32'd0);
         end else begin
            want = expected_words.pop_front();
            results_checked++;
            if (got.value_out !== want.value_out)
               report_mismatch("value_out", got.value_out, want.value_out);
            if (got.weight_out !== want.weight_out)
               report_mismatch("weight_out", got.weight_out, want.weight_out);
            if (got.index_error !== want.index_error)
               report_mismatch("index_error", got.index_error, want.index_error);
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // signals
   // -------------------------------------------------------------------------
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_word_type           req_word = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_word_type           rsp_word;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int unsigned            cycle_count = 0;
   int unsigned            hold_end = 0;
   int unsigned            idle_pct = 0;
   int unsigned            stall_pct = 0;

   factor_table_scoreboard sb = new();

   station_factor_running_mean_table_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   // cycle count and run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   // receiver: random stall, plus a long hold-off window
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= (cycle_count < hold_end) || ($urandom_range(99) < stall_pct);
      end
   end

   // monitor both channels on the edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_word);
         if (req_valid && !req_stall) sb.note_request(req_word);
      end
   end

   // -------------------------------------------------------------------------
   // driver tasks, all entered and left on a rising edge
   // -------------------------------------------------------------------------

   // offer one word, return at the edge that takes it
   task automatic send_word(req_word_type w);
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
   endtask

   // sender gaps, then one word
   task automatic send_item(op_type op, int unsigned idx, logic signed [VALUE_W-1:0] v);
      req_word_type w;
      w.op = op;
      w.station_index = INDEX_W'(idx);
      w.value_in = v;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      send_word(w);
   endtask

   // stop offering and wait for every expected word
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // write station_count, then read it back
   task automatic set_station_count(int unsigned count);
      logic [CSR_DATA_W-1:0] readback;
      drain();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= COUNT_ADDR;
      csr_pwdata <= CSR_DATA_W'(count);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.load_count(CFG_W'(count));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      // read back: the saturated count
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (readback !== CSR_DATA_W'(sb.stations_used))
         sb.report_mismatch("station_count readback", readback, sb.stations_used);
   endtask

   // random word: mostly stations in use, some out of range, mixed samples
   function automatic req_word_type random_word(int unsigned used);
      req_word_type w;
      int unsigned  pick;
      pick = $urandom_range(99);
      if (pick < 20) w.op = OP_GET;
      else if (pick < 35) w.op = OP_EVAL;
      else if (pick < 45) w.op = OP_SET;
      else w.op = OP_UPDATE;
      pick = $urandom_range(99);
      if (pick < 80 && used > 0) w.station_index = INDEX_W'($urandom_range(used - 1));
      else if (pick < 90) w.station_index = INDEX_W'(used + $urandom_range(3));
      else w.station_index = INDEX_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 50) begin
         // near the factor range, so means stay meaningful
         w.value_in = 32'sd500000 + $signed(VALUE_W'($urandom_range(131071))) - 32'sd65536;
      end else if (pick < 85) begin
         w.value_in = $urandom;
      end else begin
         case ($urandom_range(3))
            0: w.value_in = 32'sh8000_0000;
            1: w.value_in = 32'sh7FFF_FFFF;
            2: w.value_in = '0;
            default: w.value_in = -32'sd1;
         endcase
      end
      return w;
   endfunction

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------
   initial begin
      int unsigned phase_counts [6];
      phase_counts = '{16, 5, 31, 12, 1, 9};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: full table, defaults, extreme samples, range edges
      set_station_count(16);
      send_item(OP_GET, 0, '0);
      send_item(OP_GET, 6, '0);
      send_item(OP_GET, 7, '0);
      send_item(OP_EVAL, 15, '0);
      send_item(OP_SET, 3, 32'sh7FFF_FFFF);
      send_item(OP_UPDATE, 3, 32'sh8000_0000);
      send_item(OP_UPDATE, 3, 32'sh8000_0000);
      send_item(OP_UPDATE, 3, '0);
      send_item(OP_SET, 15, -32'sd1);
      send_item(OP_UPDATE, 15, 32'sh7FFF_FFFF);
      send_item(OP_GET, 16, '0);
      send_item(OP_GET, 65535, '0);
      send_item(OP_EVAL, 65535, '0);
      send_item(OP_SET, 65535, 32'sd5);
      send_item(OP_UPDATE, 16, 32'sd7);
      // empty table: evaluate gives zero
      set_station_count(0);
      send_item(OP_EVAL, 0, '0);
      send_item(OP_GET, 0, '0);
      send_item(OP_UPDATE, 0, 32'sd1);
      // count above the table size saturates; reload restores defaults
      set_station_count(31);
      send_item(OP_GET, 15, '0);
      send_item(OP_EVAL, 20, '0);
      // single station: evaluate clamps to entry 0
      set_station_count(1);
      send_item(OP_EVAL, 9, '0);
      send_item(OP_UPDATE, 0, 32'sh1234_5678);
      send_item(OP_GET, 0, '0);

      // random phases over counts and idle patterns
      for (int p = 0; p < 6; p++) begin
         set_station_count(phase_counts[p]);
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 53; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 53; end
            default: begin idle_pct = 6; stall_pct = 6; end
         endcase
         // long receiver hold-off while words keep coming
         if (p == 0) hold_end = cycle_count + 400;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // one full drain in the middle of a phase
            if (p == 4 && n == PHASE_WORDS / 2) drain();
            while ($urandom_range(99) < idle_pct) begin
               req_valid <= 1'b0;
               @(posedge clock);
            end
            send_word(random_word(sb.stations_used));
         end
      end

      // wait out the remaining results
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d get, %0d evaluate, %0d set, %0d update words; %0d out of range",
               sb.op_seen[OP_GET], sb.op_seen[OP_EVAL], sb.op_seen[OP_SET],
               sb.op_seen[OP_UPDATE], sb.range_errors);
      $display("%0d results checked over %0d station counts, peak weight %0d, %0d cycles",
               sb.results_checked, sb.count_writes, sb.peak_weight, cycle_count);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
